// ----- src/cft_pkg.sv -----
`timescale 1ns / 1ps

package cft_pkg;

    // Operation codes carried in the op field of an input transaction.
    localparam logic OP_CHECK  = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    // Action codes reported in the action field of a result transaction.
    localparam logic [1:0] ACT_CHECK   = 2'd0;
    localparam logic [1:0] ACT_REFRESH = 2'd1;
    localparam logic [1:0] ACT_ADD     = 2'd2;
    localparam logic [1:0] ACT_REPLACE = 2'd3;

    localparam int unsigned KEY_W  = 64;
    localparam int unsigned TIME_W = 48;
    localparam int unsigned CD_W   = 32;

    localparam logic [CD_W-1:0] COOLDOWN_RESET = 32'd1000000;

    typedef struct packed {
        logic              op;
        logic [KEY_W-1:0]  tbl_key;
        logic [TIME_W-1:0] now_us;
    } t_in_item;

    typedef struct packed {
        logic       skip;
        logic [1:0] action;
    } t_out_item;

endpackage

// ----- src/cooldown_filter_table.sv -----
`timescale 1ns / 1ps

// Cooldown filter table: a small table of keys, each with the time of its
// last recorded access. Both channels use valid and stall. An input
// transaction (i_in_valid high, o_in_stall low) carries an op, a key and the
// current time. A check reports skip when a stored entry for the key is still
// inside the cooldown window; a record refreshes the entry, adds a new one or
// replaces the oldest entry when the table is full. Each input transaction
// produces exactly one result transaction on o_out_valid / o_out_data.
// Timing: the scan reads one entry per cycle through a registered memory port
// into a single shared subtractor; a decide state follows for the decision
// and write-back, and a done state loads the output register. The next
// transaction can be accepted once the block is back in idle; o_in_stall
// is high while an item is in flight. The result sits in an output
// register, so a stalled receiver only holds the block once a second
// result is ready to be loaded.
// The cooldown register is written through i_cfg_we / i_cfg_wdata and resets
// to one second. Reset empties the table at once (the fill count goes to
// zero); the entry memories themselves are not cleared.

module cooldown_filter_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  cft_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output cft_pkg::t_out_item          o_out_data,
    input  logic                        i_cfg_we,
    input  logic [cft_pkg::CD_W-1:0]    i_cfg_wdata
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int DIF_W = cft_pkg::TIME_W + 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    // Entry storage: one write port and one registered read port per array.
    logic [cft_pkg::KEY_W-1:0]  r_key_mem  [TABLE_ENTRIES];
    logic [cft_pkg::TIME_W-1:0] r_time_mem [TABLE_ENTRIES];
    logic [cft_pkg::KEY_W-1:0]  r_key_rd;
    logic [cft_pkg::TIME_W-1:0] r_time_rd;

    logic [1:0]                 r_state;
    logic [CNT_W-1:0]           r_used;
    logic [CNT_W-1:0]           r_idx;
    logic                       r_rd_valid;
    logic [IDX_W-1:0]           r_cmp_idx;
    logic [cft_pkg::CD_W-1:0]   r_cooldown;

    // Item being worked on and the scan results gathered so far.
    logic                       r_op;
    logic [cft_pkg::KEY_W-1:0]  r_key;
    logic [cft_pkg::TIME_W-1:0] r_now;
    logic                       r_skip;
    logic                       r_found;
    logic [IDX_W-1:0]           r_hit;
    logic [IDX_W-1:0]           r_oldest;
    logic [cft_pkg::TIME_W-1:0] r_best;
    cft_pkg::t_out_item         r_res;

    logic                       r_out_valid;
    cft_pkg::t_out_item         r_out_data;

    logic                       issue;
    logic [IDX_W-1:0]           rd_addr;
    logic                       mem_we;
    logic                       key_we;
    logic [IDX_W-1:0]           wr_addr;
    logic [DIF_W-1:0]           sub_a;
    logic [DIF_W-1:0]           sub_b;
    logic [DIF_W-1:0]           diff;
    logic                       cooling;
    logic                       older;
    logic                       key_eq;
    logic                       full;
    logic                       out_free;

    assign issue    = (r_state == S_SCAN) && (r_idx < r_used);
    assign rd_addr  = r_idx[IDX_W-1:0];
    assign full     = (r_used >= CNT_W'(TABLE_ENTRIES));
    assign out_free = !r_out_valid || !i_out_stall;

    // The one subtractor serves both compares: for a check it forms the age
    // of the entry (now minus stored time); for a record it compares the
    // entry time against the oldest time seen so far.
    always_comb begin
        if (r_op == cft_pkg::OP_CHECK) begin
            sub_a = {1'b0, r_now};
            sub_b = {1'b0, r_time_rd};
        end else begin
            sub_a = {1'b0, r_time_rd};
            sub_b = {1'b0, r_best};
        end
    end

    assign diff    = sub_a - sub_b;
    assign older   = diff[DIF_W-1];
    assign cooling = $signed(diff) < $signed({{(DIF_W - cft_pkg::CD_W){1'b0}}, r_cooldown});
    assign key_eq  = (r_key_rd == r_key);

    // Write-back decision for a record: refresh the match, append, or evict.
    always_comb begin
        mem_we  = (r_state == S_DECIDE) && (r_op == cft_pkg::OP_RECORD);
        key_we  = mem_we && !r_found;
        if (r_found) begin
            wr_addr = r_hit;
        end else if (!full) begin
            wr_addr = r_used[IDX_W-1:0];
        end else begin
            wr_addr = r_oldest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_time_mem[wr_addr] <= r_now;
        end
        if (key_we) begin
            r_key_mem[wr_addr] <= r_key;
        end
        r_key_rd  <= r_key_mem[rd_addr];
        r_time_rd <= r_time_mem[rd_addr];
    end

    // Datapath registers for the item in flight.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_op    <= i_in_data.op;
            r_key   <= i_in_data.tbl_key;
            r_now   <= i_in_data.now_us;
            r_skip  <= 1'b0;
            r_found <= 1'b0;
            r_hit   <= '0;
            r_oldest <= '0;
            r_best  <= '0;
        end else if ((r_state == S_SCAN) && r_rd_valid) begin
            if (key_eq) begin
                r_found <= 1'b1;
                r_hit   <= r_cmp_idx;
                if (cooling) begin
                    r_skip <= 1'b1;
                end
            end
            // The first entry seeds the oldest-time search.
            if ((r_cmp_idx == '0) || older) begin
                r_oldest <= r_cmp_idx;
                r_best   <= r_time_rd;
            end
        end
        if (r_state == S_DECIDE) begin
            if (r_op == cft_pkg::OP_CHECK) begin
                r_res.skip   <= r_skip;
                r_res.action <= cft_pkg::ACT_CHECK;
            end else begin
                r_res.skip <= 1'b0;
                if (r_found) begin
                    r_res.action <= cft_pkg::ACT_REFRESH;
                end else if (!full) begin
                    r_res.action <= cft_pkg::ACT_ADD;
                end else begin
                    r_res.action <= cft_pkg::ACT_REPLACE;
                end
            end
        end
        if (r_rd_valid || issue) begin
            r_cmp_idx <= rd_addr;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_data <= r_res;
        end
    end

    // Sequencer, fill count, output valid and configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_idx       <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cooldown  <= cft_pkg::COOLDOWN_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cooldown <= i_cfg_wdata;
            end
            // A new result replaces an accepted one in the same cycle.
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_rd_valid <= issue;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (issue) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end else if (!r_rd_valid) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (mem_we && !r_found && !full) begin
                        r_used <= r_used + CNT_W'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
